// File: rtl/core/cdq_pkg.sv
`timescale 1ns / 1ps

package cdq_pkg;

   // ring geometry
   localparam int DEPTH  = 1024;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CSR_W  = 11;
   localparam int DATA_W = 32;

   // action codes
   localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [2:0] ACT_PUSH_REAR  = 3'd1;
   localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [2:0] ACT_POP_REAR   = 3'd3;
   localparam logic [2:0] ACT_QUERY      = 3'd4;

   // word reported for front and rear of an empty deque
   localparam logic signed [DATA_W-1:0] EMPTY_WORD = -32'sd1;

   typedef struct packed {
      logic [2:0]               action;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     ok;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] rear_value;
      logic                     is_empty;
      logic                     is_full;
   } rsp_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [DATA_W-1:0] wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

endpackage

// File: rtl/core/cdq_ram.sv
`timescale 1ns / 1ps

module cdq_ram #(
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [2**ADDR_W];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

// File: rtl/core/cdq_ctrl.sv
`timescale 1ns / 1ps

module cdq_ctrl
   import cdq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wen,
   input  logic [CSR_W-1:0]  csr_wdata,
   input  logic              req_fire,
   input  req_type           req_data,
   input  logic [DATA_W-1:0] ram_rdata,
   output mem_req_type       mem_req,
   output logic              busy,
   output logic              done,
   output rsp_type           result
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;

   logic              state_ff, state_in;
   logic              done_ff, done_in;
   logic              rd_rear_ff, rd_rear_in;
   logic              ok_ff, ok_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [ADDR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic signed [DATA_W-1:0] front_ff, front_in;
   logic signed [DATA_W-1:0] rear_ff, rear_in;

   logic              full, empty;
   logic [ADDR_W-1:0] tail_back;
   logic [CNT_W-1:0]  cap_clamp;

   function automatic logic [ADDR_W-1:0] step_back(input logic [ADDR_W-1:0] idx,
                                                    input logic [CNT_W-1:0]  cap);
      logic [CNT_W-1:0] last;
      last = cap - 1'b1;
      return (idx == '0) ? last[ADDR_W-1:0] : idx - 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] step_fwd(input logic [ADDR_W-1:0] idx,
                                                   input logic [CNT_W-1:0]  cap);
      logic [CNT_W-1:0] nxt;
      nxt = CNT_W'(idx) + 1'b1;
      return (nxt >= cap) ? '0 : nxt[ADDR_W-1:0];
   endfunction

   assign full      = (count_ff >= cap_ff);
   assign empty     = (count_ff == '0);
   assign tail_back = step_back(tail_ff, cap_ff);

   // clamp written capacity into 1..DEPTH
   always_comb begin
      if (csr_wdata == '0) begin
         cap_clamp = CNT_W'(1);
      end else if (32'(csr_wdata) > 32'(DEPTH)) begin
         cap_clamp = CNT_W'(DEPTH);
      end else begin
         cap_clamp = CNT_W'(csr_wdata);
      end
   end

   // action decode, pointer update and memory access
   always_comb begin
      state_in   = state_ff;
      done_in    = 1'b0;
      rd_rear_in = rd_rear_ff;
      ok_in      = ok_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      cap_in     = cap_ff;
      front_in   = front_ff;
      rear_in    = rear_ff;
      mem_req.we    = 1'b0;
      mem_req.waddr = head_ff;
      mem_req.wdata = req_data.value;
      mem_req.raddr = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               ok_in   = 1'b0;
               done_in = 1'b1;
               case (req_data.action)
                  ACT_PUSH_FRONT: begin
                     if (!full) begin
                        head_in       = step_back(head_ff, cap_ff);
                        mem_req.we    = 1'b1;
                        mem_req.waddr = head_in;
                        front_in      = req_data.value;
                        if (empty) begin
                           rear_in = req_data.value;
                        end
                        count_in = count_ff + 1'b1;
                        ok_in    = 1'b1;
                     end
                  end
                  ACT_PUSH_REAR: begin
                     if (!full) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = tail_ff;
                        tail_in       = step_fwd(tail_ff, cap_ff);
                        rear_in       = req_data.value;
                        if (empty) begin
                           front_in = req_data.value;
                        end
                        count_in = count_ff + 1'b1;
                        ok_in    = 1'b1;
                     end
                  end
                  ACT_POP_FRONT: begin
                     if (!empty) begin
                        head_in       = step_fwd(head_ff, cap_ff);
                        count_in      = count_ff - 1'b1;
                        ok_in         = 1'b1;
                        mem_req.raddr = head_in;
                        // fetch the new front unless the deque drains
                        if (count_ff != CNT_W'(1)) begin
                           done_in    = 1'b0;
                           state_in   = S_READ;
                           rd_rear_in = 1'b0;
                        end
                     end
                  end
                  ACT_POP_REAR: begin
                     if (!empty) begin
                        tail_in       = tail_back;
                        count_in      = count_ff - 1'b1;
                        ok_in         = 1'b1;
                        mem_req.raddr = step_back(tail_back, cap_ff);
                        // fetch the new rear unless the deque drains
                        if (count_ff != CNT_W'(1)) begin
                           done_in    = 1'b0;
                           state_in   = S_READ;
                           rd_rear_in = 1'b1;
                        end
                     end
                  end
                  ACT_QUERY: begin
                     ok_in = 1'b1;
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_IDLE;
            if (rd_rear_ff) begin
               rear_in = $signed(ram_rdata);
            end else begin
               front_in = $signed(ram_rdata);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // capacity write empties the deque
      if (csr_wen) begin
         cap_in   = cap_clamp;
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         done_ff    <= 1'b0;
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         cap_ff     <= CNT_W'(DEPTH);
      end else begin
         state_ff   <= state_in;
         done_ff    <= done_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         cap_ff     <= cap_in;
      end
   end

   // cached end words and result flags
   always_ff @(posedge clock) begin
      rd_rear_ff <= rd_rear_in;
      ok_ff      <= ok_in;
      front_ff   <= front_in;
      rear_ff    <= rear_in;
   end

   assign busy = done_ff || (state_ff == S_READ);
   assign done = busy;

   // assemble the response, taking fresh read data when it arrives
   always_comb begin
      result.ok       = ok_ff;
      result.is_empty = empty;
      result.is_full  = full;
      if (empty) begin
         result.front_value = EMPTY_WORD;
         result.rear_value  = EMPTY_WORD;
      end else begin
         result.front_value = front_ff;
         result.rear_value  = rear_ff;
         if (state_ff == S_READ) begin
            if (rd_rear_ff) begin
               result.rear_value = $signed(ram_rdata);
            end else begin
               result.front_value = $signed(ram_rdata);
            end
         end
      end
   end

endmodule

// File: rtl/core/circular_deque_unit.sv
`timescale 1ns / 1ps
// Each response is registered in done_ff, or in the S_READ state after a pop that leaves
// the deque non-empty, and then in the response slot; that pop takes the new end from the
// ring memory in S_READ. Requests do not overlap: the control stays busy for the cycle
// after each accepted request, and a new request also waits for a free response slot.
// Reset: pointers and count clear, capacity returns to 1024, the response slot empties;
// the ring memory is not cleared and needs no clearing pass.
module circular_deque_unit
   import cdq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wen,
   input  logic [CSR_W-1:0] csr_wdata,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   mem_req_type       mem_req;
   logic [DATA_W-1:0] ram_rdata;
   logic              busy;
   logic              done;
   rsp_type           result;
   logic              req_fire;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // take a request only when idle and the response slot can hold its result
   assign req_ready = !busy && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .req_fire  (req_fire),
      .req_data  (req_data),
      .ram_rdata (ram_rdata),
      .mem_req   (mem_req),
      .busy      (busy),
      .done      (done),
      .result    (result)
   );

   cdq_ram #(
      .WIDTH  (DATA_W),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .raddr (mem_req.raddr),
      .rdata (ram_rdata)
   );

   // hold the response until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
